@@ rtl/bmh_pkg.sv @@
package bmh_pkg;

  localparam int TEMP_W   = 10;
  localparam int MEAN_W   = 8;
  localparam int HIST_W   = 10;
  localparam int COUNT_W  = 16;
  // old*4*n + t needs 26 bits signed; its magnitude fits in 25
  localparam int SUM_W    = 27;
  localparam int DIV_W    = 26;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 10'sd508;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -10'sd508;
  localparam logic signed [MEAN_W-1:0] UNDEF_MARK = -8'sd128;
  localparam logic signed [MEAN_W-1:0] MEAN_MAX   = 8'sd127;
  localparam logic [COUNT_W-1:0]       BUCKET_RESET = 16'd338;

endpackage

@@ rtl/bucketed_mean_history_minmax_unit.sv @@
// Each sample goes through load, restoring divide, slot write, min/max scan and drain
// before its result beat is loaded, and no new sample is taken until then. One
// restoring-divider bit per cycle, plus one history-memory read per cycle for the min/max scan.
// Reset (rst, synchronous): slot index and count clear, bucket_samples returns to 338,
// then a clearing pass writes the undefined marker to every slot;
// s_axis_tready stays low during that pass.
module bucketed_mean_history_minmax_unit
  import bmh_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // bucket_samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] temperature, [15:10] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [7:0] slot_mean, [17:8] history_min,
                                      // [27:18] history_max, [31:28] zero
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam int DCW = $clog2(DIV_W);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_W - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_DIV, ST_FIN, ST_SCAN, ST_DRAIN, ST_DONE
  } state_t;

  state_t state;

  logic signed [MEAN_W-1:0] mem [HISTORY_DEPTH];
  logic signed [MEAN_W-1:0] rdata;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [MEAN_W-1:0] wr_data;

  logic [COUNT_W-1:0]       bucket_samples;
  logic [AW-1:0]            slot_index;
  logic [COUNT_W-1:0]       slot_count;
  logic [AW-1:0]            scan_addr;
  logic                     pend;

  logic signed [TEMP_W-1:0] temp;
  logic [COUNT_W-1:0]       divisor;
  logic                     neg;
  logic [DIV_W-1:0]         dq;
  logic [COUNT_W-1:0]       rem;
  logic [DCW-1:0]           div_cnt;

  logic signed [MEAN_W-1:0] mean;
  logic signed [MEAN_W-1:0] lo;
  logic signed [MEAN_W-1:0] hi;

  // input saturation
  logic signed [TEMP_W-1:0] t_in;
  logic signed [TEMP_W-1:0] t_sat;
  assign t_in  = $signed(s_axis_tdata[TEMP_W-1:0]);
  assign t_sat = (t_in > TEMP_MAX) ? TEMP_MAX : ((t_in < TEMP_MIN) ? TEMP_MIN : t_in);

  assign s_axis_tready = (state == ST_IDLE);

  // accumulate: old*4*n + t, old ignored when n is zero
  logic signed [MEAN_W-1:0] old_eff;
  logic signed [24:0]       prod;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]         sum_abs;
  logic [COUNT_W-1:0]       cnt_inc;
  always_comb begin
    old_eff = (slot_count == '0) ? '0 : rdata;
    prod    = old_eff * $signed({1'b0, slot_count});
    sum     = (SUM_W'(prod) <<< 2) + SUM_W'(temp);
    sum_abs = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
    cnt_inc = slot_count + 16'd1;
    if (cnt_inc == '0) begin
      cnt_inc = 16'd1;
    end
  end

  // one restoring-divide step
  logic [COUNT_W:0] rem_sh;
  logic [COUNT_W:0] rem_sub;
  logic             qbit;
  always_comb begin
    rem_sh  = {rem, dq[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    qbit    = (rem_sh >= {1'b0, divisor});
  end

  // final mean: truncate by four, clamp, restore sign
  logic [DIV_W-3:0]  q4;
  logic [MEAN_W-1:0] mag8;
  logic signed [MEAN_W-1:0] mean_fin;
  always_comb begin
    q4       = dq[DIV_W-1:2];
    mag8     = (q4 > (DIV_W-2)'(MEAN_MAX)) ? MEAN_MAX : {1'b0, q4[MEAN_W-2:0]};
    mean_fin = neg ? $signed(MEAN_W'(0) - mag8) : $signed(mag8);
  end

  // min/max fold of the value that came back from the memory
  logic signed [MEAN_W-1:0] fold_lo;
  logic signed [MEAN_W-1:0] fold_hi;
  always_comb begin
    fold_lo = lo;
    fold_hi = hi;
    if (pend && rdata != UNDEF_MARK) begin
      if (rdata < lo) fold_lo = rdata;
      if (rdata > hi) fold_hi = rdata;
    end
  end

  always_comb begin
    rd_addr = (state == ST_IDLE) ? slot_index : scan_addr;
    wr_en   = 1'b0;
    wr_addr = scan_addr;
    wr_data = UNDEF_MARK;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == ST_FIN) begin
      wr_en   = 1'b1;
      wr_addr = slot_index;
      wr_data = mean_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      bucket_samples <= BUCKET_RESET;
      slot_index     <= '0;
      slot_count     <= '0;
      scan_addr      <= '0;
      pend           <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_samples <= cfg_wdata;
      end
      // drop the taken beat; ST_DONE reloads it itself
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (scan_addr == LAST_ADDR) begin
            scan_addr <= '0;
            state     <= ST_IDLE;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            temp  <= t_sat;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          neg     <= sum[SUM_W-1];
          dq      <= sum_abs[DIV_W-1:0];
          rem     <= '0;
          divisor <= cnt_inc;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= qbit ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
          dq      <= {dq[DIV_W-2:0], qbit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          mean <= mean_fin;
          if (divisor >= bucket_samples) begin
            slot_count <= '0;
            slot_index <= (slot_index == LAST_ADDR) ? '0 : slot_index + 1'b1;
          end else begin
            slot_count <= divisor;
          end
          lo        <= MEAN_MAX;
          hi        <= UNDEF_MARK;
          scan_addr <= '0;
          pend      <= 1'b0;
          state     <= ST_SCAN;
        end
        ST_SCAN: begin
          lo   <= fold_lo;
          hi   <= fold_hi;
          pend <= 1'b1;
          if (scan_addr == LAST_ADDR) begin
            state <= ST_DRAIN;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          lo    <= fold_lo;
          hi    <= fold_hi;
          pend  <= 1'b0;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the previous result beat has left
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {4'b0, hi, 2'b00, lo, 2'b00, mean};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/bmh_checker.sv @@
module bmh_checker
  import bmh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic signed [MEAN_W-1:0] mean;
  logic signed [HIST_W-1:0] mean4;
  logic signed [HIST_W-1:0] hmin;
  logic signed [HIST_W-1:0] hmax;

  assign mean  = $signed(m_axis_tdata[7:0]);
  assign mean4 = $signed({m_axis_tdata[7:0], 2'b00});
  assign hmin  = $signed(m_axis_tdata[17:8]);
  assign hmax  = $signed(m_axis_tdata[27:18]);

  // one sample at a time: the input closes right after a beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

  // the current slot is defined, so its mean lies within the history range
  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (hmin <= mean4 && mean4 <= hmax))
    else $error("slot mean outside history min/max");

  a_fields_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (mean != UNDEF_MARK && m_axis_tdata[9:8] == 2'b00 &&
                       m_axis_tdata[19:18] == 2'b00 && m_axis_tdata[31:28] == 4'b0))
    else $error("result fields malformed");

endmodule

bind bucketed_mean_history_minmax_unit bmh_checker u_bmh_checker (.*);

@@ tb/bucketed_mean_history_minmax_unit_tb.sv @@
module bucketed_mean_history_minmax_unit_tb;
  import bmh_pkg::*;

  localparam int HISTORY_DEPTH  = 256;
  localparam int QUIET_LIMIT    = 6000;
  localparam int SETTLE_CYCLES  = HISTORY_DEPTH + 40;
  localparam int MEAN_LIMIT     = MEAN_MAX;
  localparam int TEMP_LIMIT     = TEMP_MAX;

  typedef struct packed {
    logic signed [MEAN_W-1:0] slot_mean;
    logic signed [HIST_W-1:0] history_min;
    logic signed [HIST_W-1:0] history_max;
  } reading_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [9:0] temperature, [15:10] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] slot_mean, [17:8] history_min, [27:18] history_max

  bucketed_mean_history_minmax_unit #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Temperature predictor state
  logic signed [MEAN_W-1:0] slot_mean_mem [HISTORY_DEPTH];
  int                       cur_slot;
  int                       slot_fill;
  logic [COUNT_W-1:0]       bucket_len;

  logic [TEMP_W-1:0] samples_to_send [$];
  reading_t          expected_readings [$];

  bit sample_taken;
  bit idle_enabled;
  int send_gap;
  int send_bursts;
  int recv_gap;
  int quiet_cycles;
  int errors;

  function automatic reading_t fold_sample(input logic signed [TEMP_W-1:0] raw);
    reading_t r;
    longint   t;
    longint   total;
    longint   q;
    int       lo;
    int       hi;
    t = raw;
    if (t > TEMP_LIMIT) t = TEMP_LIMIT;
    if (t < -TEMP_LIMIT) t = -TEMP_LIMIT;
    total = longint'(slot_mean_mem[cur_slot]) * 4 * longint'(slot_fill) + t;
    slot_fill = (slot_fill + 1) & 16'hFFFF;
    if (slot_fill == 0) slot_fill = 1;
    q = total / slot_fill;
    q = q / 4;
    if (q > MEAN_LIMIT) q = MEAN_LIMIT;
    if (q < -MEAN_LIMIT) q = -MEAN_LIMIT;
    slot_mean_mem[cur_slot] = q[MEAN_W-1:0];
    if (slot_fill >= int'(bucket_len)) begin
      cur_slot  = (cur_slot + 1) % HISTORY_DEPTH;
      slot_fill = 0;
    end
    lo = MEAN_LIMIT;
    hi = UNDEF_MARK;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (slot_mean_mem[i] == UNDEF_MARK) continue;
      if (slot_mean_mem[i] < lo) lo = slot_mean_mem[i];
      if (slot_mean_mem[i] > hi) hi = slot_mean_mem[i];
    end
    r.slot_mean   = q[MEAN_W-1:0];
    r.history_min = HIST_W'(lo * 4);
    r.history_max = HIST_W'(hi * 4);
    return r;
  endfunction

  // Mostly raw 10-bit codes; some near the rails and some clustered so means settle
  function automatic logic [TEMP_W-1:0] pick_temperature();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return TEMP_W'($urandom_range(0, 1023));
    if (sel < 8) return TEMP_W'($urandom_range(0, 1) ? $urandom_range(500, 511)
                                                      : -$urandom_range(500, 512));
    return TEMP_W'(200 - $urandom_range(0, 40));
  endfunction

  // Sender
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || sample_taken) begin
      sample_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        if (send_gap == 0 && send_bursts > 0) begin
          send_bursts--;
          send_gap = $urandom_range(1, 18);
        end
        s_axis_tvalid <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        // chain bursts now and then so valid also rises long after ready
        send_bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0;
        s_axis_tvalid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        s_axis_tdata  <= {{(16 - TEMP_W){1'b0}}, samples_to_send.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_enabled && $urandom_range(0, 15) == 0) begin
      recv_gap = $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Input beat: predict
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      sample_taken = 1'b1;
      expected_readings.push_back(fold_sample(s_axis_tdata[TEMP_W-1:0]));
    end
  end

  // Output beat: compare
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.slot_mean   = m_axis_tdata[7:0];
      got.history_min = m_axis_tdata[17:8];
      got.history_max = m_axis_tdata[27:18];
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (got.slot_mean !== want.slot_mean) begin
          $error("slot_mean expected %0d got %0d", want.slot_mean, got.slot_mean);
          errors++;
        end
        if (got.history_min !== want.history_min) begin
          $error("history_min expected %0d got %0d", want.history_min, got.history_min);
          errors++;
        end
        if (got.history_max !== want.history_max) begin
          $error("history_max expected %0d got %0d", want.history_max, got.history_max);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[bucketed_mean_history_minmax_unit] ERROR");
        $finish;
      end
    end
  end

  // Hold until every queued sample is sent and every result has come back
  task automatic drain();
    do @(negedge clk);
    while (samples_to_send.size() > 0 || s_axis_tvalid || expected_readings.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_bucket(input logic [COUNT_W-1:0] value);
    drain();
    cfg_wdata  <= value;
    cfg_we     <= 1'b1;
    bucket_len  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) samples_to_send.push_back(pick_temperature());
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    sample_taken  = 1'b0;
    idle_enabled  = 1'b1;
    send_gap      = 0;
    send_bursts   = 0;
    recv_gap      = 0;
    quiet_cycles  = 0;
    errors        = 0;
    for (int i = 0; i < HISTORY_DEPTH; i++) slot_mean_mem[i] = UNDEF_MARK;
    cur_slot   = 0;
    slot_fill  = 0;
    bucket_len = BUCKET_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Saturation on both rails, zero, sign boundaries, alternating bits
    samples_to_send.push_back(10'h1FF);
    samples_to_send.push_back(10'h200);
    samples_to_send.push_back(10'd508);
    samples_to_send.push_back(-10'sd508);
    samples_to_send.push_back(10'd509);
    samples_to_send.push_back(-10'sd509);
    samples_to_send.push_back(10'd0);
    samples_to_send.push_back(-10'sd1);
    samples_to_send.push_back(10'd1);
    samples_to_send.push_back(10'h155);
    samples_to_send.push_back(10'h2AA);

    // Zero bucket size: advance after every sample
    write_bucket(16'd0);
    samples_to_send.push_back(10'd508);
    samples_to_send.push_back(-10'sd508);
    samples_to_send.push_back(10'd3);
    samples_to_send.push_back(-10'sd3);

    // Lower the bucket size once the slot already holds more samples
    write_bucket(16'd5);
    samples_to_send.push_back(10'd100);
    samples_to_send.push_back(-10'sd100);
    samples_to_send.push_back(10'd7);
    write_bucket(16'd2);
    samples_to_send.push_back(10'd50);
    samples_to_send.push_back(10'd60);

    // One sample per slot: wrap the whole history and overwrite slots
    write_bucket(16'd1);
    send_random(280);

    write_bucket(16'hFFFF);
    idle_enabled = 1'b0;
    send_random(40);

    write_bucket(COUNT_W'($urandom_range(1, 8)));
    idle_enabled = 1'b1;
    send_random(60);
    drain();
    send_random(60);

    write_bucket(COUNT_W'($urandom_range(9, 400)));
    send_random(80);

    write_bucket(COUNT_W'($urandom_range(1, 6)));
    idle_enabled = 1'b0;
    send_random(80);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[bucketed_mean_history_minmax_unit] OK");
    end else begin
      $display("[bucketed_mean_history_minmax_unit] ERROR");
    end
    $finish;
  end

endmodule
